// File: rtl/core/bucketed_hash_set_max_merge_defines.svh
// Assertion macros for the bucketed hash set RTL.
// Files that check their own logic include this header by bare name.
`ifndef BUCKETED_HASH_SET_MAX_MERGE_DEFINES_SVH
`define BUCKETED_HASH_SET_MAX_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define BHSMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define BHSMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHSMM_ASSERT(lbl, prop, msg)
`define BHSMM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/bhsmm_pkg.sv
// Shared types and constants of the bucketed hash set.
// No dependencies; used by bhsmm_hash, the top module and the testbench.
`default_nettype none
package bhsmm_pkg;

  // Default configuration of the table
  localparam int BUCKETS_DEF      = 256;
  localparam int SLOTS_DEF        = 4;
  localparam int MAX_LEVEL_DEF    = 8;
  localparam int FEATURE_BITS_DEF = 8;

  // Fixed field geometry of a key
  localparam int LANES  = 8;
  localparam int LANE_W = 8;
  localparam int KEY_W  = LANES * LANE_W;
  localparam int LVL_W  = 4;
  localparam int VAL_W  = 32;

  // Item commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ERASE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_DUP_UPDATED = 3'd1,
    ST_DUP_KEPT    = 3'd2,
    ST_BUCKET_FULL = 3'd3,
    ST_ERASED      = 3'd4,
    ST_NOT_FOUND   = 3'd5
  } status_t;

  // One slot of a bucket row
  typedef struct packed {
    logic              valid;
    logic [LVL_W-1:0]  level;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  gamma;
    logic              real_gamma;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: rtl/core/bhsmm_row_ram.sv
// Bucket row store: one write port, one read port, registered read data.
// Depends on nothing; sized by its parameters.
`default_nettype none
module bhsmm_row_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one row, hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bhsmm_hash.sv
// Iterative bucket hash: one lane squared per cycle into an accumulator,
// then the remainder by BUCKETS through a reciprocal multiply. Depends on bhsmm_pkg.
`default_nettype none
module bhsmm_hash #(
  parameter int BUCKETS      = bhsmm_pkg::BUCKETS_DEF,
  parameter int MAX_LEVEL    = bhsmm_pkg::MAX_LEVEL_DEF,
  parameter int FEATURE_BITS = bhsmm_pkg::FEATURE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [bhsmm_pkg::LVL_W-1:0]      level,
  input  wire logic [bhsmm_pkg::KEY_W-1:0]      key,
  output logic                                  done,
  output logic [$clog2(BUCKETS)-1:0]            bucket
);

  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int SQ_MAX  = ((1 << FEATURE_BITS) - 1) * ((1 << FEATURE_BITS) - 1);
  localparam int SUM_W   = $clog2(MAX_LEVEL * SQ_MAX + 1);
  localparam int LIDX_W  = $clog2(bhsmm_pkg::LANES);

  // Rounded-up reciprocal of the bucket count; with this shift the quotient
  // is exact for every sum that fits in SUM_W bits
  localparam int SHIFT   = SUM_W + BKT_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
  localparam logic [PROD_W-1:0]  DIVISOR = PROD_W'(BUCKETS);

  typedef enum logic [1:0] {
    H_IDLE,
    H_SQUARE,
    H_MUL,
    H_REM
  } hstate_t;

  hstate_t                          state_r;
  logic [bhsmm_pkg::LVL_W-1:0]      lev_r;
  logic [bhsmm_pkg::KEY_W-1:0]      key_r;
  logic [LIDX_W-1:0]                lane_r;
  logic [SUM_W-1:0]                 sum_r;
  logic [PROD_W-1:0]                prod_r;
  logic [BKT_W-1:0]                 rem_r;
  logic                             done_r;

  logic [bhsmm_pkg::KEY_W-1:0]      key_shift;
  logic [FEATURE_BITS-1:0]          lane_val;
  logic [2*FEATURE_BITS-1:0]        square;
  logic                             last_lane;
  logic [PROD_W-1:0]                sum_ext;
  logic [PROD_W-1:0]                quot;
  logic [PROD_W-1:0]                rem_full;

  // Shared squarer on the current lane
  always_comb begin
    key_shift = key_r >> {lane_r, 3'b000};
    lane_val  = key_shift[FEATURE_BITS-1:0];
    square    = lane_val * lane_val;
    last_lane = ({{(bhsmm_pkg::LVL_W-LIDX_W){1'b0}}, lane_r} == lev_r - 4'd1);
  end

  // Quotient from the registered product, remainder by subtracting it back
  always_comb begin
    sum_ext  = {{RECIP_W{1'b0}}, sum_r};
    quot     = prod_r >> SHIFT;
    rem_full = sum_ext - quot * DIVISOR;
  end

  // Sequence the square, multiply and remainder phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        H_IDLE: begin
          if (start) begin
            lev_r   <= level;
            key_r   <= key;
            lane_r  <= '0;
            sum_r   <= '0;
            state_r <= (level == '0) ? H_MUL : H_SQUARE;
          end
        end
        H_SQUARE: begin
          sum_r <= sum_r + SUM_W'(square);
          if (last_lane) begin
            state_r <= H_MUL;
          end else begin
            lane_r <= lane_r + LIDX_W'(1);
          end
        end
        H_MUL: begin
          prod_r  <= sum_ext * {{SUM_W{1'b0}}, RECIP};
          state_r <= H_REM;
        end
        H_REM: begin
          rem_r   <= BKT_W'(rem_full);
          done_r  <= 1'b1;
          state_r <= H_IDLE;
        end
        default: begin
          state_r <= H_IDLE;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule
`default_nettype wire

// File: rtl/core/bucketed_hash_set_max_merge.sv
// Bucketed hash set of feature-index keys with max-merge on duplicates.
// Depends on bhsmm_pkg, bhsmm_hash, bhsmm_row_ram and the defines header.
//
// Usage:
//   Input channel in_*: one item per command (insert or erase) with its key,
//   level, value, gamma and real-gamma flag; taken when in_valid and in_ready
//   are both high. Result channel out_*: exactly one item per input item,
//   with status, bucket, slot and the entry count after the item.
//   The hash unit squares one lane per cycle up to the item's level, then
//   reduces the sum by the bucket count in a multiply and a remainder step;
//   the row is then read, the scan examines one slot per cycle, and the
//   update state writes back the row and loads the result once the output
//   register is free.
//   Flow: one item in flight; in_ready rises the cycle after the result
//   is loaded.
//   Reset: rst_n low clears control state; after release a clearing pass
//   empties every bucket row, one per cycle, with in_ready low.
//   Stall: a finished item waits in the output register while out_ready is
//   low; the next item may be accepted but holds before its write-back.
`default_nettype none
`include "bucketed_hash_set_max_merge_defines.svh"
module bucketed_hash_set_max_merge #(
  parameter int BUCKETS      = bhsmm_pkg::BUCKETS_DEF,
  parameter int SLOTS        = bhsmm_pkg::SLOTS_DEF,
  parameter int MAX_LEVEL    = bhsmm_pkg::MAX_LEVEL_DEF,
  parameter int FEATURE_BITS = bhsmm_pkg::FEATURE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [3:0]         in_level,
  input  wire logic [63:0]        in_feature_key,
  input  wire logic signed [31:0] in_score_value,
  input  wire logic signed [31:0] in_projected_gamma,
  input  wire logic               in_has_real_gamma,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [7:0]              out_bucket,
  output logic [1:0]              out_slot,
  output logic [10:0]             out_entry_count
);

  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCNT_W  = $clog2(SLOTS + 1);
  localparam int ENTRIES = BUCKETS * SLOTS;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ROW_W   = SLOTS * bhsmm_pkg::ENTRY_W;
  localparam logic [7:0] LANE_MASK = 8'((1 << FEATURE_BITS) - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t                                state_r;
  logic [BKT_W-1:0]                      clr_idx_r;
  logic [CNT_W-1:0]                      count_r;
  logic [CNT_W-1:0]                      count_nxt;

  // Item held while it is worked on
  logic                                  cmd_r;
  logic [bhsmm_pkg::LVL_W-1:0]           lev_r;
  logic [bhsmm_pkg::KEY_W-1:0]           key_r;
  logic signed [31:0]                    val_r;
  logic [31:0]                           gam_r;
  logic                                  real_r;
  logic [BKT_W-1:0]                      bucket_r;
  logic [SCNT_W-1:0]                     scan_r;
  logic                                  hit_r;

  // Output register
  logic                                  out_valid_r;
  logic [2:0]                            out_status_r;
  logic [7:0]                            out_bucket_r;
  logic [1:0]                            out_slot_r;
  logic [10:0]                           out_count_r;

  logic                                  in_fire;
  logic [bhsmm_pkg::LVL_W-1:0]           lev_sat;
  logic [bhsmm_pkg::KEY_W-1:0]           key_canon;

  logic                                  hash_done;
  logic [BKT_W-1:0]                      hash_bucket;

  logic                                  ram_we;
  logic [BKT_W-1:0]                      ram_waddr;
  logic [ROW_W-1:0]                      ram_wdata;
  logic                                  ram_re;
  logic [ROW_W-1:0]                      ram_rdata;

  bhsmm_pkg::entry_t [SLOTS-1:0]         row;
  bhsmm_pkg::entry_t [SLOTS:0]           row_ext;
  bhsmm_pkg::entry_t [SLOTS-1:0]         new_row;
  bhsmm_pkg::entry_t                     scan_e;
  bhsmm_pkg::entry_t                     cur_e;
  logic [SLOT_W-1:0]                     pos_idx;
  logic                                  scan_end;
  logic                                  key_match;
  logic                                  row_wr;
  logic                                  report_slot;
  bhsmm_pkg::status_t                    res_status;
  logic                                  res_load;
  logic [BKT_W+7:0]                      bkt_ext;
  logic [SLOT_W+1:0]                     slot_ext;
  logic [CNT_W+10:0]                     cnt_ext;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Saturate the level and keep only the key's own lanes
  always_comb begin
    lev_sat   = (in_level > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : in_level;
    key_canon = '0;
    for (int i = 0; i < bhsmm_pkg::LANES; i++) begin
      if (4'(i) < lev_sat) begin
        key_canon[8*i +: 8] = in_feature_key[8*i +: 8] & LANE_MASK;
      end
    end
  end

  bhsmm_hash #(
    .BUCKETS      (BUCKETS),
    .MAX_LEVEL    (MAX_LEVEL),
    .FEATURE_BITS (FEATURE_BITS)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .level  (lev_sat),
    .key    (key_canon),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  bhsmm_row_ram #(
    .DEPTH (BUCKETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (hash_bucket),
    .rd_data (ram_rdata)
  );

  assign row     = ram_rdata;
  assign row_ext = {bhsmm_pkg::entry_t'('0), row};
  assign ram_re  = (state_r == S_HASH) && hash_done;

  // Compare the slot under the scan pointer
  always_comb begin
    scan_end  = (scan_r == SCNT_W'(SLOTS));
    scan_e    = row[scan_r[SLOT_W-1:0]];
    key_match = (scan_e.level == lev_r) && (scan_e.key == key_r);
  end

  // Build the written-back row and the result of the item
  always_comb begin
    pos_idx     = scan_r[SLOT_W-1:0];
    cur_e       = row[pos_idx];
    new_row     = row;
    count_nxt   = count_r;
    row_wr      = 1'b0;
    report_slot = 1'b0;
    res_status  = bhsmm_pkg::ST_NOT_FOUND;
    if (cmd_r == bhsmm_pkg::CMD_INSERT) begin
      if (hit_r) begin
        report_slot = 1'b1;
        if (!cur_e.real_gamma && ($signed(cur_e.value) < val_r)) begin
          new_row[pos_idx].value = val_r;
          new_row[pos_idx].gamma = gam_r;
          row_wr     = 1'b1;
          res_status = bhsmm_pkg::ST_DUP_UPDATED;
        end else begin
          res_status = bhsmm_pkg::ST_DUP_KEPT;
        end
      end else if (scan_end) begin
        res_status = bhsmm_pkg::ST_BUCKET_FULL;
      end else begin
        new_row[pos_idx].valid      = 1'b1;
        new_row[pos_idx].level      = lev_r;
        new_row[pos_idx].key        = key_r;
        new_row[pos_idx].value      = val_r;
        new_row[pos_idx].gamma      = gam_r;
        new_row[pos_idx].real_gamma = real_r;
        row_wr      = 1'b1;
        report_slot = 1'b1;
        res_status  = bhsmm_pkg::ST_INSERTED;
        if (count_r < CNT_W'(ENTRIES)) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end else begin
      if (hit_r) begin
        // Shift the later slots down over the erased one
        for (int j = 0; j < SLOTS; j++) begin
          if (SCNT_W'(j) >= scan_r) begin
            new_row[j] = row_ext[j+1];
          end
        end
        row_wr      = 1'b1;
        report_slot = 1'b1;
        res_status  = bhsmm_pkg::ST_ERASED;
        if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end
  end

  assign res_load = (state_r == S_UPDATE) && (!out_valid_r || out_ready);

  // Row write: clearing pass or item write-back
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = res_load && row_wr;
      ram_waddr = bucket_r;
      ram_wdata = new_row;
    end
  end

  assign bkt_ext  = {8'b0, bucket_r};
  assign slot_ext = {2'b0, pos_idx};
  assign cnt_ext  = {11'b0, count_nxt};

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + BKT_W'(1);
          if (clr_idx_r == BKT_W'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_r   <= in_command;
            lev_r   <= lev_sat;
            key_r   <= key_canon;
            val_r   <= in_score_value;
            gam_r   <= in_projected_gamma;
            real_r  <= in_has_real_gamma;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bucket_r <= hash_bucket;
            scan_r   <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end || !scan_e.valid) begin
            hit_r   <= 1'b0;
            state_r <= S_UPDATE;
          end else if (key_match) begin
            hit_r   <= 1'b1;
            state_r <= S_UPDATE;
          end else begin
            scan_r <= scan_r + SCNT_W'(1);
          end
        end
        S_UPDATE: begin
          if (res_load) begin
            count_r      <= count_nxt;
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_bucket_r <= bkt_ext[7:0];
            out_slot_r   <= report_slot ? slot_ext[1:0] : 2'b0;
            out_count_r  <= cnt_ext[10:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_bucket      = out_bucket_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;

  // Checks on the sequencer
  `BHSMM_ASSERT(a_count_bound, count_r <= CNT_W'(ENTRIES), "entry count above table size")
  `BHSMM_ASSERT(a_write_phase, ram_we |-> (state_r == S_CLEAR || state_r == S_UPDATE), "stray row write")
  `BHSMM_ASSERT(a_count_on_load, ($past(rst_n) && !$stable(count_r)) |-> $past(res_load), "count moved")
  `BHSMM_ASSERT(a_no_overwrite, (out_valid_r && !out_ready) |=> $stable(out_status_r), "result overwritten")
  `BHSMM_ASSERT(a_accept_starts_hash, in_fire |=> (state_r == S_HASH), "accepted item not hashed")

endmodule
`default_nettype wire

// File: tb/bhsmm_result_checker.sv
`timescale 1ns / 100ps
// Result checker for bucketed_hash_set_max_merge: keeps a copy of the bucket
// store, predicts one result per accepted item and compares results in order.
// Depends on bhsmm_pkg.
module bhsmm_result_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_command,
  input  wire logic [3:0]  in_level,
  input  wire logic [63:0] in_feature_key,
  input  wire logic [31:0] in_score_value,
  input  wire logic [31:0] in_projected_gamma,
  input  wire logic        in_has_real_gamma,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_status,
  input  wire logic [7:0]  out_bucket,
  input  wire logic [1:0]  out_slot,
  input  wire logic [10:0] out_entry_count,
  output int               mismatches,
  output int               results_due
);

  localparam int TBL_BUCKETS = bhsmm_pkg::BUCKETS_DEF;
  localparam int TBL_SLOTS   = bhsmm_pkg::SLOTS_DEF;
  localparam int TBL_LEVEL   = bhsmm_pkg::MAX_LEVEL_DEF;
  localparam int TBL_ENTRIES = TBL_BUCKETS * TBL_SLOTS;
  localparam int LANE_MASK   = (1 << bhsmm_pkg::FEATURE_BITS_DEF) - 1;

  typedef struct packed {
    bhsmm_pkg::status_t status;
    logic [7:0]         bucket;
    logic [1:0]         slot;
    logic [10:0]        count;
  } table_result_t;

  // Mirror of the bucket store
  logic              row_used  [TBL_ENTRIES];
  logic [3:0]        row_level [TBL_ENTRIES];
  logic [63:0]       row_key   [TBL_ENTRIES];
  logic signed [31:0] row_value [TBL_ENTRIES];
  logic [31:0]       row_gamma [TBL_ENTRIES];
  logic              row_real  [TBL_ENTRIES];
  int unsigned       stored_total;

  table_result_t results_pending[$];

  // Apply one insert or erase to the mirror and return the result it gives
  function automatic table_result_t apply_table_op(input logic cmd,
      input logic [3:0] lvl_in, input logic [63:0] key_in,
      input logic signed [31:0] val, input logic [31:0] gam, input logic real_g);
    int unsigned   lev, sum, lane_v, bkt, base, s, j, e, i;
    logic [63:0]   ckey;
    logic          found;
    table_result_t r;
    lev  = (lvl_in > TBL_LEVEL) ? TBL_LEVEL : lvl_in;
    ckey = '0;
    sum  = 0;
    for (i = 0; i < lev; i++) begin
      lane_v = key_in[8*i +: 8] & LANE_MASK;
      ckey[8*i +: 8] = lane_v[7:0];
      sum += lane_v * lane_v;
    end
    bkt  = sum % TBL_BUCKETS;
    base = bkt * TBL_SLOTS;
    // Scan the packed slots for a key of the same level and indices
    s = 0;
    while (s < TBL_SLOTS && row_used[base+s] &&
           !(row_level[base+s] == lev && row_key[base+s] == ckey))
      s++;
    found    = (s < TBL_SLOTS) && row_used[base+s];
    r.bucket = bkt[7:0];
    r.slot   = '0;
    if (cmd == bhsmm_pkg::CMD_INSERT) begin
      if (found) begin
        e        = base + s;
        r.slot   = s[1:0];
        r.status = bhsmm_pkg::ST_DUP_KEPT;
        if (!row_real[e] && row_value[e] < val) begin
          row_value[e] = val;
          row_gamma[e] = gam;
          r.status     = bhsmm_pkg::ST_DUP_UPDATED;
        end
      end else if (s >= TBL_SLOTS) begin
        r.status = bhsmm_pkg::ST_BUCKET_FULL;
      end else begin
        e            = base + s;
        row_used[e]  = 1'b1;
        row_level[e] = lev[3:0];
        row_key[e]   = ckey;
        row_value[e] = val;
        row_gamma[e] = gam;
        row_real[e]  = real_g;
        if (stored_total < TBL_ENTRIES) stored_total++;
        r.slot   = s[1:0];
        r.status = bhsmm_pkg::ST_INSERTED;
      end
    end else begin
      if (found) begin
        // Close the gap: later entries of the bucket move down by one
        j = s + 1;
        while (j < TBL_SLOTS && row_used[base+j]) begin
          row_level[base+j-1] = row_level[base+j];
          row_key[base+j-1]   = row_key[base+j];
          row_value[base+j-1] = row_value[base+j];
          row_gamma[base+j-1] = row_gamma[base+j];
          row_real[base+j-1]  = row_real[base+j];
          j++;
        end
        row_used[base+j-1] = 1'b0;
        if (stored_total > 0) stored_total--;
        r.slot   = s[1:0];
        r.status = bhsmm_pkg::ST_ERASED;
      end else begin
        r.status = bhsmm_pkg::ST_NOT_FOUND;
      end
    end
    r.count = stored_total[10:0];
    return r;
  endfunction

  // Compare each result with the oldest prediction, then predict new items
  always @(posedge clk) begin
    table_result_t want, got;
    if (!rst_n) begin
      for (int k = 0; k < TBL_ENTRIES; k++) row_used[k] = 1'b0;
      stored_total = 0;
      results_pending.delete();
      results_due = 0;
      mismatches  = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.status = bhsmm_pkg::status_t'(out_status);
        got.bucket = out_bucket;
        got.slot   = out_slot;
        got.count  = out_entry_count;
        if (results_pending.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with none outstanding: status=%0d bucket=%0d %s%0d %s%0d",
                     $realtime, got.status, got.bucket, "slot=", got.slot,
                     "count=", got.count);
          mismatches++;
        end else begin
          want = results_pending.pop_front();
          if (got.status !== want.status || got.bucket !== want.bucket ||
              got.slot !== want.slot || got.count !== want.count) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected status=%0d bucket=%0d slot=%0d count=%0d",
                       $realtime, want.status, want.bucket, want.slot, want.count);
              $display("%0t:           got      status=%0d bucket=%0d slot=%0d count=%0d",
                       $realtime, got.status, got.bucket, got.slot, got.count);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        results_pending.push_back(apply_table_op(in_command, in_level, in_feature_key,
                                                 in_score_value, in_projected_gamma,
                                                 in_has_real_gamma));
      results_due = results_pending.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the bucketed_hash_set_max_merge testbench: clock, reset, stimulus and
// verdict. Depends on bhsmm_pkg, bhsmm_result_checker and the block itself.
module tb;

  localparam int   HOT_KEYS  = 18;
  localparam logic OP_INSERT = bhsmm_pkg::CMD_INSERT;
  localparam logic OP_ERASE  = bhsmm_pkg::CMD_ERASE;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = OP_INSERT;
  logic [3:0]  in_level = '0;
  logic [63:0] in_feature_key = '0;
  logic [31:0] in_score_value = '0;
  logic [31:0] in_projected_gamma = '0;
  logic        in_has_real_gamma = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_bucket;
  logic [1:0]  out_slot;
  logic [10:0] out_entry_count;
  int          mismatches;
  int          results_due;
  bit          no_idle = 1'b0;

  // Keys crowded into three buckets, so that duplicates, full buckets and
  // erases with shifting all come up often
  logic [3:0]  hot_level [HOT_KEYS];
  logic [63:0] hot_key   [HOT_KEYS];

  bucketed_hash_set_max_merge DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_level           (in_level),
    .in_feature_key     (in_feature_key),
    .in_score_value     (in_score_value),
    .in_projected_gamma (in_projected_gamma),
    .in_has_real_gamma  (in_has_real_gamma),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_bucket         (out_bucket),
    .out_slot           (out_slot),
    .out_entry_count    (out_entry_count)
  );

  bhsmm_result_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_level           (in_level),
    .in_feature_key     (in_feature_key),
    .in_score_value     (in_score_value),
    .in_projected_gamma (in_projected_gamma),
    .in_has_real_gamma  (in_has_real_gamma),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_bucket         (out_bucket),
    .out_slot           (out_slot),
    .out_entry_count    (out_entry_count),
    .mismatches         (mismatches),
    .results_due        (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Drive one item at the falling edge after a random gap; hold until taken
  task automatic send_item(input logic cmd, input logic [3:0] lvl, input logic [63:0] key,
                           input logic [31:0] val, input logic [31:0] gam,
                           input logic real_g);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command         <= cmd;
    in_level           <= lvl;
    in_feature_key     <= key;
    in_score_value     <= val;
    in_projected_gamma <= gam;
    in_has_real_gamma  <= real_g;
    in_valid           <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Use a crowded key, with random bytes above its level and a level of
  // 8 to 15 where the key has all eight indices
  task automatic send_hot(input logic cmd);
    int          h;
    logic [3:0]  lvl;
    logic [63:0] mask, key;
    h    = $urandom_range(0, HOT_KEYS - 1);
    lvl  = (hot_level[h] == bhsmm_pkg::MAX_LEVEL_DEF) ? 4'($urandom_range(8, 15))
                                                       : hot_level[h];
    mask = (hot_level[h] >= 8) ? '1 : ((64'd1 << (8 * hot_level[h])) - 64'd1);
    key  = (hot_key[h] & mask) | ({$urandom, $urandom} & ~mask);
    send_item(cmd, lvl, key, pick_q16(), pick_q16(), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: stall a random number of cycles before each result
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int           lvl, pos, pick;
    logic [7:0]   seed_lane;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Build the crowded keys: lanes that are multiples of 16 square to zero
    // modulo the bucket count, so one lane alone picks bucket 0, 1 or 9
    for (int i = 0; i < HOT_KEYS; i++) begin
      seed_lane = (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd1 : 8'd3;
      lvl = (i % 3 == 0) ? $urandom_range(0, 8) : $urandom_range(1, 8);
      hot_level[i] = 4'(lvl);
      hot_key[i]   = '0;
      for (int l = 0; l < lvl; l++) hot_key[i][8*l +: 8] = 8'($urandom_range(0, 15) * 16);
      if (lvl > 0) begin
        pos = $urandom_range(0, lvl - 1);
        hot_key[i][8*pos +: 8] = seed_lane;
      end
    end

    // Directed: fill bucket 0, merge rules, overflow, saturation, erase shifts
    send_item(OP_INSERT, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_item(OP_INSERT, 4'd0, 64'h1234_5678_9ABC_DEF0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(OP_INSERT, 4'd0, 64'h0, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_item(OP_INSERT, 4'd1, 64'hA5A5_A5A5_A5A5_A510, 32'h0, 32'h0, 1'b1);
    send_item(OP_INSERT, 4'd1, 64'h5A5A_5A5A_5A5A_5A10, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_item(OP_INSERT, 4'd2, 64'hFFFF_FFFF_FFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    send_item(OP_INSERT, 4'd3, 64'h0000_0000_0040_3020, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_item(OP_INSERT, 4'd1, 64'h0000_0000_0000_00F0, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd1, 64'hFFFF_FFFF_FFFF_FF10, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd1, 64'h0000_0000_0000_0010, 32'h0, 32'h0, 1'b0);
    send_item(OP_INSERT, 4'd1, 64'hFFFF_FFFF_FFFF_FFF0, 32'h0, 32'h0, 1'b0);
    send_item(OP_INSERT, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFB_0000, 32'h0, 1'b0);
    send_item(OP_INSERT, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFD_0000, 32'h1, 1'b1);
    send_item(OP_INSERT, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFC_0000, 32'h2, 1'b0);
    send_item(OP_ERASE,  4'd12, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd0, 64'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd3, 64'hFFFF_FFFF_FF40_3020, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd2, 64'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd1, 64'h0000_0000_0000_00F0, 32'h0, 32'h0, 1'b0);
    send_item(OP_ERASE,  4'd0, 64'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_INSERT, 4'd8, 64'h0, 32'h0, 32'h8000_0000, 1'b1);
    send_item(OP_ERASE,  4'd8, 64'h0, 32'h0, 32'h0, 1'b0);

    // Random: mostly crowded keys, the rest fully random items
    for (int n = 0; n < 1230; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // Hold the sender until every outstanding result is back
      if (n % 300 == 150) begin
        in_valid <= 1'b0;
        wait (results_due == 0);
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_hot(OP_INSERT);
      else if (pick < 80)
        send_hot(OP_ERASE);
      else
        send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), {$urandom, $urandom},
                  pick_q16(), pick_q16(), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then give a late stray result time to show up
    wait (results_due == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("bucketed_hash_set_max_merge test passed");
    else
      $display("bucketed_hash_set_max_merge test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bucketed_hash_set_max_merge test failed");
    $finish;
  end

endmodule

// File: bucketed_hash_set_max_merge.f
+incdir+rtl/core
rtl/core/bhsmm_pkg.sv
rtl/core/bhsmm_row_ram.sv
rtl/core/bhsmm_hash.sv
rtl/core/bucketed_hash_set_max_merge.sv
tb/bhsmm_result_checker.sv
tb/tb.sv
